### src/rrms_pkg.sv
// rrms_pkg: widths, limits and handoff structs of the running rms level detector
// no dependencies; used by the interfaces, rrms_cmpsub, rrms_seq and the top level
package rrms_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int CHANNELS    = 2;
	localparam int CH_BITS     = 1;
	localparam int WIN_BITS    = 16;
	localparam int MS_BITS     = 2 * SAMPLE_BITS - 2;
	localparam int ROOT_BITS   = MS_BITS / 2;
	localparam int HALF_BITS   = MS_BITS / 2;
	localparam int PROD_BITS   = HALF_BITS + WIN_BITS;
	localparam int ACC_BITS    = MS_BITS + WIN_BITS;
	localparam int UNIT_BITS   = ROOT_BITS + 3;
	localparam int DIV_STEPS   = MS_BITS;
	localparam int SQRT_STEPS  = ROOT_BITS;
	localparam int CNT_BITS    = 6;

	localparam logic [WIN_BITS-1:0] WIN_RESET = 16'd960;
	localparam logic [MS_BITS-1:0]  MS_MAX    = {MS_BITS{1'b1}};

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [MS_BITS-1:0]     ms_t;
	typedef logic [WIN_BITS-1:0]    win_t;
	typedef logic [UNIT_BITS-1:0]   unit_t;

	typedef struct packed {
		logic    start;
		sample_t sample;
		ms_t     ms;
		win_t    win;
	} rrms_cmd_t;

	typedef struct packed {
		logic    done;
		ms_t     ms;
		sample_t rms;
	} rrms_res_t;

endpackage

### src/rrms_if.sv
// rrms_if: valid/ready channel interfaces for samples, levels and the window setting
// depends on rrms_pkg
interface rrms_in_if import rrms_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [CH_BITS-1:0]            channel;

	modport source (output valid, output sample, output channel, input ready);
	modport sink (input valid, input sample, input channel, output ready);
endinterface

interface rrms_out_if import rrms_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] rms_level;
	logic [CH_BITS-1:0]     out_channel;

	modport source (output valid, output rms_level, output out_channel, input ready);
	modport sink (input valid, input rms_level, input out_channel, output ready);
endinterface

interface rrms_cfg_if import rrms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WIN_BITS-1:0] window_len;

	modport source (output valid, output window_len, input ready);
	modport sink (input valid, input window_len, output ready);
endinterface

### src/rrms_cmpsub.sv
// rrms_cmpsub: shared compare-and-subtract unit for the divide and root steps
// depends on rrms_pkg
module rrms_cmpsub import rrms_pkg::*; (
	input  unit_t a,
	input  unit_t b,
	output logic  ge,
	output unit_t diff
);
	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = !borrow;
endmodule

### src/rrms_seq.sv
// rrms_seq: sequencer for one update: square, multiply, divide by n, square root
// depends on rrms_pkg and rrms_cmpsub
module rrms_seq import rrms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rrms_cmd_t cmd,
	input  logic      ack,
	output logic      idle,
	output rrms_res_t res
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQUARE = 3'd1;
	localparam logic [2:0] ST_MUL_LO = 3'd2;
	localparam logic [2:0] ST_MUL_HI = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_SQRT   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]           state_q;
	logic [CNT_BITS-1:0]  cnt_q;
	sample_t              mag_q;
	ms_t                  ms_q;
	win_t                 n_q;
	win_t                 m_q;
	logic [ACC_BITS-1:0]  acc_q;
	ms_t                  work_q;
	unit_t                rem_q;
	logic [ROOT_BITS-1:0] root_q;

	sample_t                  mag_in;
	win_t                     n_in;
	logic [2*SAMPLE_BITS-1:0] sq_full;
	ms_t                      sq_sat;
	logic [HALF_BITS-1:0]     ms_half;
	logic [PROD_BITS-1:0]     prod;
	logic [ACC_BITS-1:0]      acc_add;
	logic [ACC_BITS-1:0]      acc_sum;
	unit_t                    unit_a;
	unit_t                    unit_b;
	unit_t                    unit_diff;
	logic                     unit_ge;

	assign mag_in = cmd.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~cmd.sample + 1'b1) : cmd.sample;
	assign n_in   = (cmd.win == '0) ? WIN_BITS'(1) : cmd.win;

	assign sq_full = mag_q * mag_q;
	assign sq_sat  = (sq_full[2*SAMPLE_BITS-1:MS_BITS] != '0) ? MS_MAX : sq_full[MS_BITS-1:0];

	// one multiplier, low half then high half of the mean square
	assign ms_half = (state_q == ST_MUL_LO) ? ms_q[HALF_BITS-1:0] : ms_q[MS_BITS-1:HALF_BITS];
	assign prod    = ms_half * m_q;
	assign acc_add = (state_q == ST_MUL_LO) ? {{(ACC_BITS-PROD_BITS){1'b0}}, prod}
		: {prod, {HALF_BITS{1'b0}}};
	assign acc_sum = acc_q + acc_add;

	always_comb begin
		if (state_q == ST_SQRT) begin
			unit_a = {rem_q[UNIT_BITS-3:0], work_q[MS_BITS-1 -: 2]};
			unit_b = {1'b0, root_q, 2'b01};
		end else begin
			unit_a = {{(UNIT_BITS-WIN_BITS-1){1'b0}}, rem_q[WIN_BITS-1:0], work_q[MS_BITS-1]};
			unit_b = {{(UNIT_BITS-WIN_BITS){1'b0}}, n_q};
		end
	end

	rrms_cmpsub u_cmpsub (
		.a    (unit_a),
		.b    (unit_b),
		.ge   (unit_ge),
		.diff (unit_diff)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: begin
					state_q <= ST_DIV;
					cnt_q   <= CNT_BITS'(DIV_STEPS - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= CNT_BITS'(SQRT_STEPS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					mag_q <= mag_in;
					ms_q  <= cmd.ms;
					n_q   <= n_in;
					m_q   <= n_in - WIN_BITS'(1);
				end
			end
			ST_SQUARE: acc_q <= {{WIN_BITS{1'b0}}, sq_sat};
			ST_MUL_LO: acc_q <= acc_sum;
			ST_MUL_HI: begin
				// quotient fits the mean square, so the top bits start below n
				rem_q  <= {{(UNIT_BITS-WIN_BITS){1'b0}}, acc_sum[ACC_BITS-1:MS_BITS]};
				work_q <= acc_sum[MS_BITS-1:0];
			end
			ST_DIV: begin
				work_q <= {work_q[MS_BITS-2:0], unit_ge};
				if (cnt_q == '0) begin
					ms_q   <= {work_q[MS_BITS-2:0], unit_ge};
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					rem_q <= {{(UNIT_BITS-WIN_BITS){1'b0}},
						unit_ge ? unit_diff[WIN_BITS-1:0] : unit_a[WIN_BITS-1:0]};
				end
			end
			ST_SQRT: begin
				rem_q  <= unit_ge ? unit_diff : unit_a;
				root_q <= {root_q[ROOT_BITS-2:0], unit_ge};
				work_q <= {work_q[MS_BITS-3:0], 2'b00};
			end
			default: ;
		endcase
	end

	assign idle     = (state_q == ST_IDLE);
	assign res.done = (state_q == ST_DONE);
	assign res.ms   = ms_q;
	assign res.rms  = {{(SAMPLE_BITS-ROOT_BITS){1'b0}}, root_q};

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < {{(UNIT_BITS-WIN_BITS){1'b0}}, n_q})
		else $error("division remainder not below divisor");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> rem_q[UNIT_BITS-1 -: 2] == 2'b00)
		else $error("root remainder overflow");

	a_ms_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_SQRT && ms_q == work_q))
		else $error("quotient not captured at end of division");
endmodule

### src/running_rms_level_detector_unit.sv
// running_rms_level_detector_unit: top level, window register, per-channel mean square,
// output register; depends on rrms_pkg, rrms_if and rrms_seq
//
// Each accepted sample updates its channel's mean square to (ms*(n-1) + x*x) / n and returns
// the floor square root as the level. A sample occupies the core from its accepting cycle on:
// capture, squaring, low and high half products on a shared 23x16 multiplier, 46 restoring
// divide steps and 23 root steps on one shared 26-bit compare-subtract unit, and a handoff
// into the output register, held while that register still has an unaccepted level.
// samples.ready is low during that time, so no new sample is taken until the last is handed
// off; the level waits in the output register while the next sample is already worked on.
module running_rms_level_detector_unit import rrms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rrms_cfg_if.sink    setup,
	rrms_in_if.sink     samples,
	rrms_out_if.source  levels
);
	win_t               window_q;
	ms_t                mean_square_q [CHANNELS];
	logic [CH_BITS-1:0] ch_q;
	logic               out_valid_q;
	sample_t            rms_q;
	logic [CH_BITS-1:0] out_ch_q;

	rrms_cmd_t cmd;
	rrms_res_t res;
	logic      core_idle;
	logic      ack;

	assign samples.ready = core_idle;
	assign setup.ready   = 1'b1;

	assign cmd.start  = samples.valid && samples.ready;
	assign cmd.sample = samples.sample;
	assign cmd.ms     = mean_square_q[samples.channel];
	assign cmd.win    = window_q;

	assign ack = res.done && (!out_valid_q || levels.ready);

	rrms_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ack    (ack),
		.idle   (core_idle),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				mean_square_q[i] <= '0;
			end
		end else begin
			if (setup.valid && setup.ready) begin
				window_q <= setup.window_len;
			end
			if (ack) begin
				out_valid_q            <= 1'b1;
				mean_square_q[ch_q]    <= res.ms;
			end else if (levels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ch_q <= samples.channel;
		end
		if (ack) begin
			rms_q    <= res.rms;
			out_ch_q <= ch_q;
		end
	end

	assign levels.valid       = out_valid_q;
	assign levels.rms_level   = rms_q;
	assign levels.out_channel = out_ch_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		ack |=> (levels.valid && levels.rms_level[SAMPLE_BITS-1] == 1'b0))
		else $error("level not presented or out of range");

	a_state_write: assert property (@(posedge clk) disable iff (!arst_n)
		ack |=> mean_square_q[$past(ch_q)] == $past(res.ms))
		else $error("mean square not stored for channel");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(levels.valid && !levels.ready) |=> (levels.valid && $stable(levels.rms_level)
			&& $stable(levels.out_channel)))
		else $error("level transaction changed while stalled");
endmodule
